// ===== hdl/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum block.
// Used by the cell, the top level and the checker; no dependencies.
package swm_pkg;

  localparam int unsigned WINDOW_MAX_DEF   = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned CFG_W            = 7;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_ABSORB = 2'd1,
    OP_POP    = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     first;
    logic     shift;
  } cell_ctrl_t;

endpackage

// ===== hdl/swm_cell.sv =====
// One deque entry of the candidate chain: value, age and valid flag.
// Takes its neighbor's entry on a shift; depends on swm_pkg.
module swm_cell #(
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned CNT_W        = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swm_pkg::cell_ctrl_t            ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           head_i,
  input  logic                           left_keep_i,
  input  logic                           right_keep_i,
  input  logic                           right_valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_value_i,
  input  logic        [CNT_W-1:0]        right_age_i,
  output logic                           valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] value_o,
  output logic        [CNT_W-1:0]        age_o,
  output logic                           keep_o,
  output logic signed [SAMPLE_WIDTH-1:0] nxt_value_o
);

  logic                           valid_q, valid_d;
  logic signed [SAMPLE_WIDTH-1:0] value_q, value_d;
  logic        [CNT_W-1:0]        age_q, age_d;
  logic                           keep;
  logic                           src_keep;
  logic signed [SAMPLE_WIDTH-1:0] src_value;
  logic        [CNT_W-1:0]        src_age;
  logic                           prev_keep;

  assign keep = valid_q && !ctrl_i.first && !(value_q < sample_i);

  always_comb begin
    src_keep  = ctrl_i.shift ? right_keep_i  : keep;
    src_value = ctrl_i.shift ? right_value_i : value_q;
    src_age   = ctrl_i.shift ? right_age_i   : age_q;
    prev_keep = head_i || (ctrl_i.shift ? keep : left_keep_i);
    valid_d   = valid_q;
    value_d   = value_q;
    age_d     = age_q;
    unique case (ctrl_i.op)
      swm_pkg::OP_ABSORB: begin
        if (src_keep) begin
          valid_d = 1'b1;
          value_d = src_value;
          age_d   = src_age + CNT_W'(1);
        end else if (prev_keep) begin
          valid_d = 1'b1;
          value_d = sample_i;
          age_d   = '0;
        end else begin
          valid_d = 1'b0;
        end
      end
      swm_pkg::OP_POP: begin
        valid_d = right_valid_i;
        value_d = right_value_i;
        age_d   = right_age_i;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
  end

  assign valid_o     = valid_q;
  assign value_o     = value_q;
  assign age_o       = age_q;
  assign keep_o      = keep;
  assign nxt_value_o = value_d;

endmodule

// ===== hdl/sliding_window_maximum.sv =====
// Top level of the sliding window maximum: config register, chain of cells,
// sample counter and output register. Depends on swm_pkg and swm_cell.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o     sample_i, first_i
//   out       output     out_valid_o / out_stall_i   window_max_o
//   config    input      window_size_we_i            window_size_i
//
// One sample is absorbed per cycle unless in_stall_o is high; all cells compare
// against it in parallel. The result shows on the output in the cycle after
// the sample is taken, once the window has filled. After window_size shrinks,
// expired entries pop off the head one per cycle while in_stall_o is high.
// Reset empties the chain, clears the sample count and sets window_size to 1.
// A stalled output beat holds and stalls the input.
module sliding_window_maximum #(
  parameter int unsigned WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            window_size_we_i,
  input  logic        [swm_pkg::CFG_W-1:0] window_size_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_i,
  input  logic                            first_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]  window_max_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CMP_W = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;

  logic [CNT_W-1:0] win_q, win_d;
  logic [CMP_W-1:0] win_raw;
  logic [CNT_W-1:0] seen_q, seen_d;
  logic [CNT_W-1:0] seen_base;
  logic [CNT_W:0]   seen_inc;
  logic             out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] out_value_q, out_value_d;

  logic                           cell_valid [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
  logic        [CNT_W-1:0]        cell_age   [WINDOW_MAX];
  logic                           cell_keep  [WINDOW_MAX];
  logic                           r_valid    [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] r_value    [WINDOW_MAX];
  logic        [CNT_W-1:0]        r_age      [WINDOW_MAX];
  logic                           r_keep     [WINDOW_MAX];
  logic                           l_keep     [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] head_nxt;

  logic                expire_head;
  logic                cleanup;
  logic                accept;
  swm_pkg::cell_ctrl_t ctrl;

  always_comb begin
    win_raw = CMP_W'(window_size_i);
    win_d   = win_q;
    if (window_size_we_i) begin
      if (win_raw == '0) begin
        win_d = CNT_W'(1);
      end else if (win_raw > CMP_W'(WINDOW_MAX)) begin
        win_d = CNT_W'(WINDOW_MAX);
      end else begin
        win_d = CNT_W'(win_raw);
      end
    end
  end

  assign expire_head = cell_valid[0] &&
                       (({1'b0, cell_age[0]} + (CNT_W+1)'(1)) >= {1'b0, win_q});
  assign cleanup     = cell_valid[0] && (cell_age[0] >= win_q);
  assign in_stall_o  = cleanup || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    ctrl.first = first_i;
    ctrl.shift = expire_head && !first_i;
    if (accept) begin
      ctrl.op = swm_pkg::OP_ABSORB;
    end else if (cleanup) begin
      ctrl.op = swm_pkg::OP_POP;
    end else begin
      ctrl.op = swm_pkg::OP_HOLD;
    end
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == WINDOW_MAX - 1) begin : g_tail
      assign r_valid[i] = 1'b0;
      assign r_value[i] = '0;
      assign r_age[i]   = '0;
      assign r_keep[i]  = 1'b0;
    end else begin : g_link
      assign r_valid[i] = cell_valid[i+1];
      assign r_value[i] = cell_value[i+1];
      assign r_age[i]   = cell_age[i+1];
      assign r_keep[i]  = cell_keep[i+1];
    end
    if (i == 0) begin : g_head
      assign l_keep[i] = 1'b1;
      swm_cell #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .CNT_W       (CNT_W)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .sample_i     (sample_i),
        .head_i       (1'b1),
        .left_keep_i  (l_keep[i]),
        .right_keep_i (r_keep[i]),
        .right_valid_i(r_valid[i]),
        .right_value_i(r_value[i]),
        .right_age_i  (r_age[i]),
        .valid_o      (cell_valid[i]),
        .value_o      (cell_value[i]),
        .age_o        (cell_age[i]),
        .keep_o       (cell_keep[i]),
        .nxt_value_o  (head_nxt)
      );
    end else begin : g_body
      assign l_keep[i] = cell_keep[i-1];
      swm_cell #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .CNT_W       (CNT_W)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .sample_i     (sample_i),
        .head_i       (1'b0),
        .left_keep_i  (l_keep[i]),
        .right_keep_i (r_keep[i]),
        .right_valid_i(r_valid[i]),
        .right_value_i(r_value[i]),
        .right_age_i  (r_age[i]),
        .valid_o      (cell_valid[i]),
        .value_o      (cell_value[i]),
        .age_o        (cell_age[i]),
        .keep_o       (cell_keep[i]),
        .nxt_value_o  ()
      );
    end
  end

  always_comb begin
    seen_base   = first_i ? '0 : seen_q;
    seen_inc    = {1'b0, seen_base} + (CNT_W+1)'(1);
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    if (accept) begin
      seen_d      = (seen_inc >= {1'b0, win_q}) ? win_q : seen_inc[CNT_W-1:0];
      out_valid_d = (seen_inc >= {1'b0, win_q});
      out_value_d = head_nxt;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= CNT_W'(1);
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = out_value_q;

endmodule

// ===== hdl/swm_checker.sv =====
// Port-level checks for the sliding window maximum, bound to the top level.
// Depends on swm_pkg and on the port list of sliding_window_maximum.
module swm_port_checks #(
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            window_size_we_i,
  input logic        [swm_pkg::CFG_W-1:0] window_size_i,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic signed [SAMPLE_WIDTH-1:0]  sample_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [SAMPLE_WIDTH-1:0]  window_max_o
);

  logic unit_win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_win_q <= 1'b1;
    end else if (window_size_we_i) begin
      unit_win_q <= (window_size_i == swm_pkg::CFG_W'(0)) ||
                    (window_size_i == swm_pkg::CFG_W'(1));
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_max_o))
    else $error("stalled output beat changed");

  a_skid_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output beat is held");

  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("output beat without an input beat");

  a_unit_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && unit_win_q && !window_size_we_i |=>
      out_valid_o && window_max_o == $past(sample_i))
    else $error("window of one must pass the sample through");

endmodule

bind sliding_window_maximum swm_port_checks #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_swm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .window_size_we_i(window_size_we_i),
  .window_size_i   (window_size_i),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .sample_i        (sample_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .window_max_o    (window_max_o)
);

// ===== bench/swm_checker.sv =====
// Checker for the sliding window maximum: watches the config, input and output
// channels, keeps its own candidate deque and compares every output beat.
// Depends on swm_pkg.
module swm_checker (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        window_size_we_i,
  input  logic        [swm_pkg::CFG_W-1:0]            window_size_i,
  input  logic                                        in_valid_i,
  input  logic                                        in_stall_i,
  input  logic signed [swm_pkg::SAMPLE_WIDTH_DEF-1:0] sample_i,
  input  logic                                        first_i,
  input  logic                                        out_valid_i,
  input  logic                                        out_stall_i,
  input  logic signed [swm_pkg::SAMPLE_WIDTH_DEF-1:0] window_max_i,
  output int unsigned                                 fail_count_o,
  output int unsigned                                 pending_o,
  output int unsigned                                 checked_o
);

  localparam int unsigned SW  = swm_pkg::SAMPLE_WIDTH_DEF;
  localparam int unsigned WIN = swm_pkg::WINDOW_MAX_DEF;
  localparam int unsigned AGE_SAT = (1 << swm_pkg::CFG_W) - 1;

  typedef struct {
    logic signed [SW-1:0] value;
    int unsigned          age;
  } candidate_t;

  candidate_t                 window_deque[$];
  logic signed [SW-1:0]       expected_max[$];
  logic [swm_pkg::CFG_W-1:0]  window_cfg;
  int unsigned                seen;
  int unsigned                fails = 0;
  int unsigned                checks = 0;

  assign fail_count_o = fails;
  assign checked_o    = checks;

  function automatic int unsigned effective_window(input logic [swm_pkg::CFG_W-1:0] cfg);
    if (cfg == '0) return 1;
    if (cfg > WIN) return WIN;
    return cfg;
  endfunction

  function automatic void absorb_sample(input logic signed [SW-1:0] s, input logic f);
    int unsigned w;
    candidate_t  c;
    w = effective_window(window_cfg);
    if (f) begin
      window_deque.delete();
      seen = 0;
    end
    foreach (window_deque[i]) begin
      if (window_deque[i].age < AGE_SAT) window_deque[i].age = window_deque[i].age + 1;
    end
    while (window_deque.size() > 0 && window_deque[0].age >= w) window_deque.delete(0);
    while (window_deque.size() > 0 && window_deque[window_deque.size()-1].value < s) begin
      window_deque.delete(window_deque.size() - 1);
    end
    c.value = s;
    c.age   = 0;
    if (window_deque.size() < WIN) window_deque.insert(window_deque.size(), c);
    if (seen < w) seen++;
    if (seen > w) seen = w;
    if (seen >= w && window_deque.size() > 0) begin
      expected_max.insert(expected_max.size(), window_deque[0].value);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [SW-1:0] want;
    if (!rst_ni) begin
      window_cfg = 1;
      seen       = 0;
      window_deque.delete();
      expected_max.delete();
    end else begin
      if (in_valid_i && !in_stall_i) absorb_sample(sample_i, first_i);
      if (window_size_we_i) window_cfg = window_size_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_max.size() == 0) begin
          $error("window_max: no beat expected, actual %0d", window_max_i);
          fails++;
        end else begin
          want = expected_max[0];
          expected_max.delete(0);
          checks++;
          if (window_max_i !== want) begin
            $error("window_max mismatch: expected %0d, actual %0d", want, window_max_i);
            fails++;
          end
        end
      end
    end
    pending_o = expected_max.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for sliding_window_maximum: clock, reset, window size phases,
// sample stimulus with random idling and the verdict. Depends on swm_pkg,
// sliding_window_maximum and swm_checker.
module tb_top;

  localparam int unsigned SW  = swm_pkg::SAMPLE_WIDTH_DEF;
  localparam int unsigned WIN = swm_pkg::WINDOW_MAX_DEF;
  localparam int unsigned N_PHASES = 13;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef enum int unsigned {
    SHAPE_NOISE,
    SHAPE_FALL,
    SHAPE_RISE,
    SHAPE_NARROW,
    SHAPE_RAIL
  } shape_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        window_size_we_i;
  logic [swm_pkg::CFG_W-1:0]   window_size_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic signed [SW-1:0]        sample_i;
  logic                        first_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [SW-1:0]        window_max_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned sent;
  int unsigned settings_used;
  logic        quiet;
  logic        in_taken;

  int unsigned window_plan [N_PHASES] = '{64, 5, 127, 2, 0, 40, 1, 64, 8, 16, 33, 64, 3};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
  end

  sliding_window_maximum u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .window_size_we_i (window_size_we_i),
    .window_size_i    (window_size_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .first_i          (first_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .window_max_o     (window_max_o)
  );

  swm_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .window_size_we_i (window_size_we_i),
    .window_size_i    (window_size_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .sample_i         (sample_i),
    .first_i          (first_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .window_max_i     (window_max_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  task automatic send_sample(input logic signed [SW-1:0] s, input logic f);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = s;
    first_i    = f;
    do @(negedge clk_i); while (!in_taken);
    sent++;
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [swm_pkg::CFG_W-1:0] v);
    window_size_we_i = 1'b1;
    window_size_i    = v;
    @(negedge clk_i);
    window_size_we_i = 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input int unsigned n_items, input int unsigned cfg);
    int unsigned          k;
    int unsigned          run_left;
    int unsigned          w_eff;
    shape_e               shape;
    logic signed [SW-1:0] level;
    logic signed [SW-1:0] s;
    logic                 f;
    w_eff    = (cfg == 0) ? 1 : (cfg > WIN) ? WIN : cfg;
    run_left = 0;
    shape    = SHAPE_NOISE;
    level    = '0;
    for (k = 0; k < n_items; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 70);
        shape    = shape_e'($urandom_range(SHAPE_NOISE, SHAPE_RAIL));
        level    = SW'($urandom);
      end
      run_left--;
      case (shape)
        SHAPE_NOISE: s = SW'($urandom);
        SHAPE_FALL: begin
          level = level - SW'($urandom_range(0, 3));
          s     = level;
        end
        SHAPE_RISE: begin
          level = level + SW'($urandom_range(0, 3));
          s     = level;
        end
        SHAPE_NARROW: s = SW'($urandom_range(0, 4)) - SW'(2);
        default: s = $urandom_range(0, 1) ? {1'b0, {(SW-1){1'b1}}} : {1'b1, {(SW-1){1'b0}}};
      endcase
      f = ($urandom_range(0, 2 * w_eff + 20) == 0);
      send_sample(s, f);
    end
  endtask

  initial begin
    int unsigned left;
    left        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (left != 0) begin
        out_stall_i = 1'b1;
        left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i = 1'b1;
        left = $urandom_range(1, 14) - 1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  initial begin
    int unsigned p;
    rst_ni           = 1'b0;
    window_size_we_i = 1'b0;
    window_size_i    = '0;
    in_valid_i       = 1'b0;
    sample_i         = '0;
    first_i          = 1'b0;
    quiet            = 1'b0;
    sent             = 0;
    settings_used    = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset window of one, stream taken to start at reset
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    settle();
    write_window(swm_pkg::CFG_W'(3));
    send_sample(-16'sd5, 1'b1);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd50, 1'b0);
    send_sample(16'sd20, 1'b0);
    send_sample(16'sd10, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd3, 1'b0);

    for (p = 0; p < N_PHASES; p++) begin
      settle();
      write_window(swm_pkg::CFG_W'(window_plan[p]));
      if (p >= N_PHASES - 2) quiet = 1'b1;
      run_phase(PHASE_ITEMS, window_plan[p]);
    end

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Covered %0d samples over %0d window size writes; %0d window maxima compared",
             sent, settings_used, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/sliding_window_maximum.sv
hdl/swm_checker.sv
bench/swm_checker.sv
bench/tb_top.sv
